// ===== rtl/core/pcm_pkg.sv =====
// ============================================================================
// pcm_pkg: shared types and constants of the primaries conversion matrix
// Request and result types, the queue job format, field widths and the fixed
// BT.2020 source RGB-to-XYZ matrix in Q1.30.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

package pcm_pkg;

  // field and datapath widths
  localparam int IN_W    = 16;
  localparam int C_W     = 18;
  localparam int ADJ_W   = 37;
  localparam int A_W     = 57;
  localparam int MS_W    = 32;
  localparam int S_W     = 71;
  localparam int SPLIT   = 36;
  localparam int P_W     = 52;
  localparam int NUM_W   = 88;
  localparam int MAT_W   = 24;
  localparam int DIV_LAT = MAT_W + 2;
  localparam int ONE_Q16 = 65536;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_ZERO_Y    = 2'd1,
    ST_SINGULAR  = 2'd2,
    ST_SATURATED = 2'd3
  } pcm_status_e;

  typedef struct packed {
    logic [IN_W-1:0] red_x;
    logic [IN_W-1:0] red_y;
    logic [IN_W-1:0] green_x;
    logic [IN_W-1:0] green_y;
    logic [IN_W-1:0] blue_x;
    logic [IN_W-1:0] blue_y;
    logic [IN_W-1:0] white_x;
    logic [IN_W-1:0] white_y;
  } pcm_in_t;

  typedef struct packed {
    logic signed [MAT_W-1:0] m_r0c0;
    logic signed [MAT_W-1:0] m_r0c1;
    logic signed [MAT_W-1:0] m_r0c2;
    logic signed [MAT_W-1:0] m_r1c0;
    logic signed [MAT_W-1:0] m_r1c1;
    logic signed [MAT_W-1:0] m_r1c2;
    logic signed [MAT_W-1:0] m_r2c0;
    logic signed [MAT_W-1:0] m_r2c1;
    logic signed [MAT_W-1:0] m_r2c2;
    pcm_status_e             status;
  } pcm_out_t;

  // classified request waiting for the back end
  typedef struct packed {
    logic [2:0][2:0][ADJ_W-1:0] adj;
    logic [2:0][A_W-1:0]        a;
    logic [IN_W-1:0]            wy;
    pcm_status_e                status;
  } pcm_job_t;

  typedef struct packed {
    logic full;
    logic empty;
  } pcm_qstat_t;

  typedef struct packed {
    logic             sat;
    logic [MAT_W-1:0] val;
  } pcm_div_res_t;

  // cyclic successor of a 3x3 index
  function automatic int nx(input int i);
    return (i == 2) ? 0 : i + 1;
  endfunction

  // BT.2020 primaries and D65 white in Q0.16
  localparam logic signed [127:0] SRC_X [4] = '{128'sd46399, 128'sd11141, 128'sd8585,
                                                 128'sd20493};
  localparam logic signed [127:0] SRC_Y [4] = '{128'sd19137, 128'sd52232, 128'sd3015,
                                                 128'sd21561};

  function automatic logic signed [127:0] src_c(input int r, input int k);
    logic signed [127:0] v;
    if (r == 0) begin
      v = SRC_X[k];
    end else if (r == 1) begin
      v = SRC_Y[k];
    end else begin
      v = 128'sd65536 - SRC_X[k] - SRC_Y[k];
    end
    return v;
  endfunction

  function automatic logic signed [127:0] src_adj(input int i, input int j);
    return src_c(nx(j), nx(i)) * src_c(nx(nx(j)), nx(nx(i)))
         - src_c(nx(j), nx(nx(i))) * src_c(nx(nx(j)), nx(i));
  endfunction

  function automatic logic signed [127:0] src_a(input int i);
    logic signed [127:0] s;
    s = '0;
    for (int k = 0; k < 3; k++) begin
      s = s + src_adj(i, k) * src_c(k, 3);
    end
    return s;
  endfunction

  function automatic logic signed [127:0] src_det();
    logic signed [127:0] s;
    s = '0;
    for (int j = 0; j < 3; j++) begin
      s = s + src_c(0, j) * src_adj(j, 0);
    end
    return s;
  endfunction

  function automatic logic signed [127:0] src_num(input int k, input int j);
    return (src_c(k, j) * src_a(j)) <<< 30;
  endfunction

  function automatic logic [127:0] abs128(input logic signed [127:0] v);
    return (v < 0) ? -v : v;
  endfunction

  localparam logic signed [127:0] SRC_DEN = src_det() * SRC_Y[3];
  localparam logic [127:0]        MS_RDEN = abs128(SRC_DEN) << 1;

  // rounding numerator: 2|n| + |d| over 2|d| gives half away from zero
  function automatic logic [127:0] ms_rnum(input int k, input int j);
    return (abs128(src_num(k, j)) << 1) + abs128(SRC_DEN);
  endfunction

  localparam logic [127:0] MS_MAG [3][3] = '{
    '{ms_rnum(0, 0) / MS_RDEN, ms_rnum(0, 1) / MS_RDEN, ms_rnum(0, 2) / MS_RDEN},
    '{ms_rnum(1, 0) / MS_RDEN, ms_rnum(1, 1) / MS_RDEN, ms_rnum(1, 2) / MS_RDEN},
    '{ms_rnum(2, 0) / MS_RDEN, ms_rnum(2, 1) / MS_RDEN, ms_rnum(2, 2) / MS_RDEN}
  };

  function automatic logic signed [MS_W-1:0] ms_coef(input int k, input int j);
    logic [MS_W-1:0] m;
    m = MS_MAG[k][j][MS_W-1:0];
    return ((src_num(k, j) < 0) != (SRC_DEN < 0)) ? -$signed(m) : $signed(m);
  endfunction

  // source RGB-to-XYZ matrix, Q1.30
  localparam logic signed [MS_W-1:0] MS [3][3] = '{
    '{ms_coef(0, 0), ms_coef(0, 1), ms_coef(0, 2)},
    '{ms_coef(1, 0), ms_coef(1, 1), ms_coef(1, 2)},
    '{ms_coef(2, 0), ms_coef(2, 1), ms_coef(2, 2)}
  };

endpackage

`default_nettype wire

// ===== rtl/core/primaries_conversion_matrix_unit.sv =====
// ============================================================================
// primaries_conversion_matrix_unit: BT.2020 to target RGB matrix generator
// Front end, job queue and pipelined back end with per-element dividers.
// ============================================================================
// Takes one target primary set (red, green, blue, white chromaticities in
// Q0.16) per request and returns the 3x3 matrix from linear BT.2020 RGB to
// target RGB in saturating Q7.16, plus a status code. One request is
// accepted every cycle unless the queue is full; each matrix element passes
// through its own divider pipeline of 24 restoring steps. A queue of
// QUEUE_DEPTH jobs sits between the front end and the back end, so input
// stalls only when the queue is full. A zero y gives status 1, a singular
// set status 2, both with an all-zero matrix; a clamped element gives status 3.
`timescale 1ns / 1ps
`default_nettype none

module primaries_conversion_matrix_unit #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  pcm_pkg::pcm_in_t  in_req_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output pcm_pkg::pcm_out_t out_req_o
);
  import pcm_pkg::*;

  logic       push, pop;
  pcm_job_t   push_job, head_job;
  pcm_qstat_t q_stat;

  // intake and classification
  pcm_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_req_i   (in_req_i),
    .q_full_i   (q_stat.full),
    .push_o     (push),
    .job_o      (push_job)
  );

  // job queue
  pcm_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_job_i (push_job),
    .pop_i      (pop),
    .head_o     (head_job),
    .stat_o     (q_stat)
  );

  // matrix arithmetic
  pcm_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_i      (head_job),
    .q_stat_i    (q_stat),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_req_o   (out_req_o)
  );

endmodule

`default_nettype wire

// ===== rtl/core/pcm_front.sv =====
// ============================================================================
// pcm_front: request intake and classification
// Builds the target chromaticity matrix, its adjugate, the white scale
// factors and the determinant, flags zero y and singular sets, and pushes a
// job into the queue.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module pcm_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  pcm_pkg::pcm_in_t  in_req_i,
  input  logic              q_full_i,
  output logic              push_o,
  output pcm_pkg::pcm_job_t job_o
);
  import pcm_pkg::*;

  logic                    front_adv;
  logic [IN_W-1:0]         xs [4];
  logic [IN_W-1:0]         ys [4];
  logic signed [C_W-1:0]   c [3][4];
  logic signed [ADJ_W-1:0] adj_d [3][3];
  logic                    zy_d;

  logic                    v1_q, v2_q;
  logic signed [ADJ_W-1:0] adj1_q [3][3];
  logic signed [C_W-1:0]   w1_q [3];
  logic signed [C_W-1:0]   c01_q [3];
  logic [IN_W-1:0]         wy1_q;
  logic                    zy1_q;

  logic signed [A_W-1:0]   a_d [3];
  logic signed [A_W-1:0]   det_d;

  logic signed [ADJ_W-1:0] adj2_q [3][3];
  logic signed [A_W-1:0]   a2_q [3];
  logic [IN_W-1:0]         wy2_q;
  logic                    zy2_q;
  logic                    dz2_q;

  // front pipeline moves unless its last request cannot enter the queue
  assign front_adv  = !v2_q || !q_full_i;
  assign in_stall_o = !front_adv;
  assign push_o     = v2_q && !q_full_i;

  // chromaticity columns (x, y, z) and adjugate
  always_comb begin
    xs[0] = in_req_i.red_x;
    ys[0] = in_req_i.red_y;
    xs[1] = in_req_i.green_x;
    ys[1] = in_req_i.green_y;
    xs[2] = in_req_i.blue_x;
    ys[2] = in_req_i.blue_y;
    xs[3] = in_req_i.white_x;
    ys[3] = in_req_i.white_y;
    zy_d  = 1'b0;
    for (int k = 0; k < 4; k++) begin
      c[0][k] = $signed({2'b00, xs[k]});
      c[1][k] = $signed({2'b00, ys[k]});
      c[2][k] = C_W'(ONE_Q16) - c[0][k] - c[1][k];
      zy_d    = zy_d || (ys[k] == '0);
    end
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        adj_d[i][j] = ADJ_W'(c[nx(j)][nx(i)] * c[nx(nx(j))][nx(nx(i))])
                    - ADJ_W'(c[nx(j)][nx(nx(i))] * c[nx(nx(j))][nx(i)]);
      end
    end
  end

  // white scale factors and determinant
  always_comb begin
    det_d = '0;
    for (int i = 0; i < 3; i++) begin
      a_d[i] = '0;
      for (int k = 0; k < 3; k++) begin
        a_d[i] = a_d[i] + A_W'(adj1_q[i][k] * w1_q[k]);
      end
      det_d = det_d + A_W'(c01_q[i] * adj1_q[i][0]);
    end
  end

  // stage valids
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else if (front_adv) begin
      v1_q <= in_valid_i;
      v2_q <= v1_q;
    end
  end

  // stage payloads
  always_ff @(posedge clk_i) begin
    if (front_adv) begin
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          adj1_q[i][j] <= adj_d[i][j];
          adj2_q[i][j] <= adj1_q[i][j];
        end
        w1_q[i]  <= c[i][3];
        c01_q[i] <= c[0][i];
        a2_q[i]  <= a_d[i];
      end
      wy1_q <= ys[3];
      zy1_q <= zy_d;
      wy2_q <= wy1_q;
      zy2_q <= zy1_q;
      dz2_q <= (det_d == '0);
    end
  end

  // classify and pack the job
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        job_o.adj[i][j] = adj2_q[i][j];
      end
      job_o.a[i] = a2_q[i];
    end
    job_o.wy = wy2_q;
    if (zy2_q) begin
      job_o.status = ST_ZERO_Y;
    end else if (dz2_q || (a2_q[0] == '0) || (a2_q[1] == '0) || (a2_q[2] == '0)) begin
      job_o.status = ST_SINGULAR;
    end else begin
      job_o.status = ST_OK;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/pcm_queue.sv =====
// ============================================================================
// pcm_queue: job queue between front and back end
// Small register FIFO so each side can stall on its own.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module pcm_queue #(
  parameter int DEPTH = 4
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  pcm_pkg::pcm_job_t   push_job_i,
  input  logic                pop_i,
  output pcm_pkg::pcm_job_t   head_o,
  output pcm_pkg::pcm_qstat_t stat_o
);
  import pcm_pkg::*;

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  pcm_job_t        mem_q [DEPTH];
  logic [PW-1:0]   wr_ptr_q, rd_ptr_q;
  logic [CW-1:0]   cnt_q;

  // storage write
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_job_i;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (!push_i && pop_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  assign head_o       = mem_q[rd_ptr_q];
  assign stat_o.full  = (cnt_q == CW'(DEPTH));
  assign stat_o.empty = (cnt_q == '0);

`ifndef SYNTHESIS
  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !stat_o.full) else $error("push into full queue");
  a_no_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> !stat_o.empty) else $error("pop from empty queue");
  a_empty_ptrs: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stat_o.empty |-> (wr_ptr_q == rd_ptr_q)) else $error("pointers apart while empty");
`endif

endmodule

`default_nettype wire

// ===== rtl/core/pcm_div.sv =====
// ============================================================================
// pcm_div: pipelined rounding divider with Q7.16 saturation
// One quotient bit per restoring stage; rounds half away from zero and clamps.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module pcm_div (
  input  logic                     clk_i,
  input  logic                     en_i,
  input  logic [pcm_pkg::NUM_W-1:0] num_i,
  input  logic [pcm_pkg::A_W-1:0]   den_i,
  input  logic                     neg_i,
  output pcm_pkg::pcm_div_res_t    res_o
);
  import pcm_pkg::*;

  localparam int DW = A_W + 15;
  localparam int RW = DW + MAT_W;
  localparam logic [MAT_W-1:0] LIM_POS = {1'b0, {(MAT_W - 1){1'b1}}};
  localparam logic [MAT_W-1:0] LIM_NEG = {1'b1, {(MAT_W - 1){1'b0}}};

  logic [RW-1:0]    r_q [DIV_LAT];
  logic [RW-1:0]    r_d [DIV_LAT];
  logic [DW-1:0]    dp_q [DIV_LAT];
  logic [DW-1:0]    dp_d [DIV_LAT];
  logic [MAT_W-1:0] q_q [DIV_LAT];
  logic [MAT_W-1:0] q_d [DIV_LAT];
  logic             ovf_q [DIV_LAT];
  logic             ovf_d [DIV_LAT];
  logic             neg_q [DIV_LAT];
  logic             neg_d [DIV_LAT];
  logic [RW-1:0]    trial [2:DIV_LAT-1];
  logic [MAT_W-1:0] lim, qf, mag;
  logic             sat;

  // prep (2n + d over 2d), overflow check, then restoring steps
  always_comb begin
    r_d[0]   = RW'({num_i, 1'b0}) + RW'({den_i, 14'b0});
    dp_d[0]  = {den_i, 15'b0};
    q_d[0]   = '0;
    ovf_d[0] = 1'b0;
    neg_d[0] = neg_i;
    r_d[1]   = r_q[0];
    dp_d[1]  = dp_q[0];
    q_d[1]   = '0;
    ovf_d[1] = (r_q[0] >= {dp_q[0], {MAT_W{1'b0}}});
    neg_d[1] = neg_q[0];
    for (int s = 2; s < DIV_LAT; s++) begin
      trial[s] = RW'(dp_q[s-1]) << (DIV_LAT - 1 - s);
      dp_d[s]  = dp_q[s-1];
      ovf_d[s] = ovf_q[s-1];
      neg_d[s] = neg_q[s-1];
      if (r_q[s-1] >= trial[s]) begin
        r_d[s] = r_q[s-1] - trial[s];
        q_d[s] = q_q[s-1] | (MAT_W'(1) << (DIV_LAT - 1 - s));
      end else begin
        r_d[s] = r_q[s-1];
        q_d[s] = q_q[s-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int s = 0; s < DIV_LAT; s++) begin
        r_q[s]   <= r_d[s];
        dp_q[s]  <= dp_d[s];
        q_q[s]   <= q_d[s];
        ovf_q[s] <= ovf_d[s];
        neg_q[s] <= neg_d[s];
      end
    end
  end

  // clamp and apply sign
  always_comb begin
    lim       = neg_q[DIV_LAT-1] ? LIM_NEG : LIM_POS;
    qf        = q_q[DIV_LAT-1];
    sat       = ovf_q[DIV_LAT-1] || (qf > lim);
    mag       = sat ? lim : qf;
    res_o.sat = sat;
    res_o.val = neg_q[DIV_LAT-1] ? -mag : mag;
  end

endmodule

`default_nettype wire

// ===== rtl/core/pcm_back.sv =====
// ============================================================================
// pcm_back: matrix product, scaling and division
// Multiplies the target adjugate by the source matrix, scales by white y,
// divides by the white scale factors and registers the result.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module pcm_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  pcm_pkg::pcm_job_t   head_i,
  input  pcm_pkg::pcm_qstat_t q_stat_i,
  output logic                pop_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output pcm_pkg::pcm_out_t   out_req_o
);
  import pcm_pkg::*;

  localparam int B_LAT = 4 + DIV_LAT;

  logic                    back_adv;
  logic                    vp_q [B_LAT];
  pcm_status_e             stp_q [B_LAT];

  logic signed [S_W-1:0]   s_d [3][3];
  logic signed [S_W-1:0]   s1_q [3][3];
  logic signed [A_W-1:0]   a1_q [3];
  logic [IN_W-1:0]         wy1_q;

  logic [P_W-1:0]          plo2_q [3][3];
  logic signed [P_W-1:0]   phi2_q [3][3];
  logic signed [A_W-1:0]   a2_q [3];

  logic signed [NUM_W-1:0] num3_q [3][3];
  logic signed [A_W-1:0]   a3_q [3];

  logic [NUM_W-1:0]        nmag4_q [3][3];
  logic [A_W-1:0]          amag4_q [3];
  logic                    neg4_q [3][3];

  pcm_div_res_t            div_res [3][3];
  logic [MAT_W-1:0]        mat [3][3];
  pcm_status_e             st_fin;
  logic                    sat_any;
  logic                    out_valid_q;
  pcm_out_t                out_req_d, out_req_q;

  assign back_adv = !(out_valid_q && out_stall_i);
  assign pop_o    = back_adv && !q_stat_i.empty;

  // adjugate times source matrix
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        s_d[i][j] = '0;
        for (int k = 0; k < 3; k++) begin
          s_d[i][j] = s_d[i][j] + S_W'($signed(head_i.adj[i][k]) * MS[k][j]);
        end
      end
    end
  end

  // valid and status line
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int s = 0; s < B_LAT; s++) begin
        vp_q[s] <= 1'b0;
      end
      out_valid_q <= 1'b0;
    end else if (back_adv) begin
      vp_q[0] <= pop_o;
      for (int s = 1; s < B_LAT; s++) begin
        vp_q[s] <= vp_q[s-1];
      end
      out_valid_q <= vp_q[B_LAT-1];
    end
  end

  // datapath stages
  always_ff @(posedge clk_i) begin
    if (back_adv) begin
      stp_q[0] <= head_i.status;
      for (int s = 1; s < B_LAT; s++) begin
        stp_q[s] <= stp_q[s-1];
      end
      wy1_q <= head_i.wy;
      for (int i = 0; i < 3; i++) begin
        a1_q[i]    <= $signed(head_i.a[i]);
        a2_q[i]    <= a1_q[i];
        a3_q[i]    <= a2_q[i];
        amag4_q[i] <= a3_q[i][A_W-1] ? A_W'(-a3_q[i]) : A_W'(a3_q[i]);
        for (int j = 0; j < 3; j++) begin
          s1_q[i][j]    <= s_d[i][j];
          // white y scaling split in two partial products
          plo2_q[i][j]  <= P_W'(s1_q[i][j][SPLIT-1:0] * wy1_q);
          phi2_q[i][j]  <= P_W'($signed(s1_q[i][j][S_W-1:SPLIT]) * $signed({1'b0, wy1_q}));
          num3_q[i][j]  <= $signed({phi2_q[i][j], {SPLIT{1'b0}}})
                         + $signed({{(NUM_W - P_W){1'b0}}, plo2_q[i][j]});
          nmag4_q[i][j] <= num3_q[i][j][NUM_W-1] ? NUM_W'(-num3_q[i][j])
                                                 : NUM_W'(num3_q[i][j]);
          neg4_q[i][j]  <= num3_q[i][j][NUM_W-1] ^ a3_q[i][A_W-1];
        end
      end
      out_req_q <= out_req_d;
    end
  end

  // element dividers
  for (genvar gi = 0; gi < 3; gi++) begin : g_row
    for (genvar gj = 0; gj < 3; gj++) begin : g_col
      pcm_div u_div (
        .clk_i (clk_i),
        .en_i  (back_adv),
        .num_i (nmag4_q[gi][gj]),
        .den_i (amag4_q[gi]),
        .neg_i (neg4_q[gi][gj]),
        .res_o (div_res[gi][gj])
      );
    end
  end

  // final status and zeroing of rejected requests
  always_comb begin
    sat_any = 1'b0;
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        sat_any   = sat_any || div_res[i][j].sat;
        mat[i][j] = (stp_q[B_LAT-1] == ST_OK) ? div_res[i][j].val : '0;
      end
    end
    if (stp_q[B_LAT-1] != ST_OK) begin
      st_fin = stp_q[B_LAT-1];
    end else if (sat_any) begin
      st_fin = ST_SATURATED;
    end else begin
      st_fin = ST_OK;
    end
    out_req_d.m_r0c0 = mat[0][0];
    out_req_d.m_r0c1 = mat[0][1];
    out_req_d.m_r0c2 = mat[0][2];
    out_req_d.m_r1c0 = mat[1][0];
    out_req_d.m_r1c1 = mat[1][1];
    out_req_d.m_r1c2 = mat[1][2];
    out_req_d.m_r2c0 = mat[2][0];
    out_req_d.m_r2c1 = mat[2][1];
    out_req_d.m_r2c2 = mat[2][2];
    out_req_d.status = st_fin;
  end

  assign out_valid_o = out_valid_q;
  assign out_req_o   = out_req_q;

endmodule

`default_nettype wire

// ===== sim/tb.sv =====
// ============================================================================
// tb: self-checking bench for primaries_conversion_matrix_unit
// Drives target primary sets with random gaps. Predicts each matrix and its
// status with wide exact integer arithmetic, and checks every result in
// order against that prediction while the output side stalls at random.
// ============================================================================
`timescale 1ns / 1ps

module tb;
  import pcm_pkg::*;

  typedef logic signed [255:0] wide_t;

  localparam int NUM_RANDOM = 1725;
  localparam int HOLD_CYCLES = 400;

  logic     clk_i;
  logic     rst_ni;
  logic     in_valid_i;
  logic     in_stall_o;
  pcm_in_t  in_req_i;
  logic     out_valid_o;
  logic     out_stall_i;
  pcm_out_t out_req_o;

  primaries_conversion_matrix_unit uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_req_i   (in_req_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_req_o  (out_req_o)
  );

  pcm_in_t  primaries_pending [$];
  bit       drain_before [$];
  pcm_out_t matrix_expected [$];
  wide_t    bt2020_xyz [3][3];
  int       gap_cnt;
  int       stall_cnt;
  int       hold_cnt;
  bit       hold_done;
  int       results_seen;
  int       errors;
  int       status_seen [4];
  bit       stim_ready;
  string    field_name [10] = '{"m_r0c0", "m_r0c1", "m_r0c2", "m_r1c0", "m_r1c1",
                                "m_r1c2", "m_r2c0", "m_r2c1", "m_r2c2", "status"};

  // clock
  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  function automatic wide_t mag(input wide_t v);
    return (v < 0) ? -v : v;
  endfunction

  // magnitude of n / d rounded half away from zero
  function automatic wide_t div_round(input wide_t n, input wide_t d);
    return (2 * mag(n) + mag(d)) / (2 * mag(d));
  endfunction

  // chromaticity columns, adjugate, white scale factors and determinant
  function automatic void primaries_setup(input wide_t xs[4], input wide_t ys[4],
                                          output wide_t cm[3][3],
                                          output wide_t adj[3][3],
                                          output wide_t scale[3], output wide_t det);
    wide_t wv[3];
    for (int j = 0; j < 3; j++) begin
      cm[0][j] = xs[j];
      cm[1][j] = ys[j];
      cm[2][j] = 65536 - xs[j] - ys[j];
    end
    wv[0] = xs[3];
    wv[1] = ys[3];
    wv[2] = 65536 - xs[3] - ys[3];
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        adj[i][j] = cm[(j+1)%3][(i+1)%3] * cm[(j+2)%3][(i+2)%3]
                  - cm[(j+1)%3][(i+2)%3] * cm[(j+2)%3][(i+1)%3];
      end
    end
    for (int i = 0; i < 3; i++) begin
      scale[i] = 0;
      for (int k = 0; k < 3; k++) scale[i] = scale[i] + adj[i][k] * wv[k];
    end
    det = cm[0][0] * adj[0][0] + cm[0][1] * adj[1][0] + cm[0][2] * adj[2][0];
  endfunction

  // fixed BT.2020 RGB-to-XYZ matrix in Q1.30
  function automatic void build_bt2020();
    wide_t xs[4], ys[4], cm[3][3], adj[3][3], scale[3], det, num, den, q;
    xs = '{46399, 11141, 8585, 20493};
    ys = '{19137, 52232, 3015, 21561};
    primaries_setup(xs, ys, cm, adj, scale, det);
    den = det * ys[3];
    for (int k = 0; k < 3; k++) begin
      for (int j = 0; j < 3; j++) begin
        num = (cm[k][j] * scale[j]) <<< 30;
        q = div_round(num, den);
        bt2020_xyz[k][j] = ((num < 0) != (den < 0)) ? -q : q;
      end
    end
  endfunction

  function automatic pcm_out_t predict_matrix(input pcm_in_t r);
    wide_t xs[4], ys[4], cm[3][3], adj[3][3], scale[3], det, num, den, q, lim;
    logic [MAT_W-1:0] elem [9];
    pcm_status_e st;
    bit neg;
    pcm_out_t res;
    xs[0] = r.red_x;   ys[0] = r.red_y;
    xs[1] = r.green_x; ys[1] = r.green_y;
    xs[2] = r.blue_x;  ys[2] = r.blue_y;
    xs[3] = r.white_x; ys[3] = r.white_y;
    st = ST_OK;
    for (int i = 0; i < 9; i++) elem[i] = '0;
    for (int i = 0; i < 4; i++) if (ys[i] == 0) st = ST_ZERO_Y;
    if (st == ST_OK) begin
      primaries_setup(xs, ys, cm, adj, scale, det);
      if (det == 0 || scale[0] == 0 || scale[1] == 0 || scale[2] == 0) st = ST_SINGULAR;
    end
    if (st == ST_OK) begin
      for (int i = 0; i < 3; i++) begin
        den = scale[i] * 16384;
        for (int j = 0; j < 3; j++) begin
          num = 0;
          for (int k = 0; k < 3; k++) num = num + adj[i][k] * ys[3] * bt2020_xyz[k][j];
          neg = (num < 0) != (den < 0);
          q = div_round(num, den);
          lim = neg ? 8388608 : 8388607;
          if (q > lim) begin
            q = lim;
            st = ST_SATURATED;
          end
          q = neg ? -q : q;
          elem[i*3+j] = q[MAT_W-1:0];
        end
      end
    end
    res.m_r0c0 = elem[0]; res.m_r0c1 = elem[1]; res.m_r0c2 = elem[2];
    res.m_r1c0 = elem[3]; res.m_r1c1 = elem[4]; res.m_r1c2 = elem[5];
    res.m_r2c0 = elem[6]; res.m_r2c1 = elem[7]; res.m_r2c2 = elem[8];
    res.status = st;
    return res;
  endfunction

  function automatic pcm_in_t make_set(input int rx, ry, gx, gy, bx, by, wx, wy);
    pcm_in_t s;
    s.red_x = 16'(rx);   s.red_y = 16'(ry);   s.green_x = 16'(gx); s.green_y = 16'(gy);
    s.blue_x = 16'(bx);  s.blue_y = 16'(by);  s.white_x = 16'(wx); s.white_y = 16'(wy);
    return s;
  endfunction

  function automatic int jitter(input int v, input int span);
    int r;
    r = v + $signed($urandom_range(2 * span)) - span;
    return (r < 0) ? 0 : (r > 65535) ? 65535 : r;
  endfunction

  // plausible display gamut with random content
  function automatic pcm_in_t display_set(input int span);
    return make_set(jitter(44000, span), jitter(21000, span), jitter(17000, span),
                    jitter(45000, span), jitter(9800, span), jitter(4500, span),
                    jitter(20500, span), jitter(21600, span));
  endfunction

  task automatic add_set(input pcm_in_t s, input bit drain);
    primaries_pending.push_back(s);
    drain_before.push_back(drain);
  endtask

  // stimulus
  initial begin
    pcm_in_t s;
    int pick;
    build_bt2020();
    // directed: common gamuts, identity, extremes, zero y, singular, saturation
    add_set(make_set(46399, 19137, 11141, 52232, 8585, 3015, 20493, 21561), 1'b0);
    add_set(make_set(41943, 21627, 19661, 39322, 9830, 3932, 20493, 21561), 1'b0);
    add_set(make_set(44564, 20972, 17433, 45220, 9830, 3932, 20493, 21561), 1'b0);
    add_set(make_set(65535, 65535, 65535, 65535, 65535, 65535, 65535, 65535), 1'b0);
    add_set(make_set(0, 65535, 65535, 1, 1, 1, 65535, 65535), 1'b0);
    add_set(make_set(0, 0, 0, 0, 0, 0, 0, 0), 1'b0);
    add_set(make_set(41943, 0, 19661, 39322, 9830, 3932, 20493, 21561), 1'b0);
    add_set(make_set(41943, 21627, 19661, 0, 9830, 3932, 20493, 21561), 1'b0);
    add_set(make_set(41943, 21627, 19661, 39322, 9830, 0, 20493, 21561), 1'b0);
    add_set(make_set(41943, 21627, 19661, 39322, 9830, 3932, 20493, 0), 1'b0);
    add_set(make_set(10000, 10000, 20000, 20000, 30000, 30000, 20493, 21561), 1'b0);
    add_set(make_set(41943, 21627, 41943, 21627, 9830, 3932, 20493, 21561), 1'b0);
    add_set(make_set(41943, 21627, 19661, 39322, 9830, 3932, 41943, 21627), 1'b0);
    add_set(make_set(20000, 20000, 20010, 20000, 20000, 20010, 20493, 21561), 1'b0);
    add_set(make_set(20400, 21500, 20600, 21600, 20450, 21700, 20493, 21561), 1'b0);
    add_set(make_set(30000, 1, 1, 30000, 1, 1, 20493, 21561), 1'b0);
    add_set(make_set(65535, 1, 1, 65535, 1, 1, 21845, 21845), 1'b0);
    add_set(make_set(52000, 30000, 60000, 50000, 5000, 2000, 40000, 40000), 1'b0);
    // random: mostly plausible gamuts, some narrow, some with a repeated primary or a zero y, some raw noise
    for (int n = 0; n < NUM_RANDOM; n++) begin
      pick = $urandom_range(99);
      if (pick < 60) begin
        s = display_set($urandom_range(1, 6000));
      end else if (pick < 70) begin
        s = display_set(20000);
      end else if (pick < 75) begin
        s = make_set(jitter(20500, 300), jitter(21600, 300), jitter(20500, 300),
                     jitter(21600, 300), jitter(20500, 300), jitter(21600, 300),
                     jitter(20500, 300), jitter(21600, 300));
      end else if (pick < 80) begin
        s = display_set(4000);
        s.green_x = s.red_x;
        s.green_y = s.red_y;
      end else if (pick < 84) begin
        s = display_set(4000);
        case ($urandom_range(3))
          0: s.red_y = '0;
          1: s.green_y = '0;
          2: s.blue_y = '0;
          default: s.white_y = '0;
        endcase
      end else begin
        s = pcm_in_t'({$urandom, $urandom, $urandom, $urandom});
      end
      add_set(s, n == NUM_RANDOM / 2);
    end
    stim_ready = 1'b1;
  end

  // reset
  initial begin
    rst_ni = 1'b0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  // request driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      in_req_i   <= '0;
      gap_cnt    <= 0;
    end else begin
      if (in_valid_i && !in_stall_o) matrix_expected.push_back(predict_matrix(in_req_i));
      if (!in_valid_i || !in_stall_o) begin
        if (gap_cnt > 0) begin
          in_valid_i <= 1'b0;
          gap_cnt    <= gap_cnt - 1;
        end else if (stim_ready && primaries_pending.size() > 0 &&
                     !(drain_before[0] && (matrix_expected.size() > 0))) begin
          in_valid_i <= 1'b1;
          in_req_i   <= primaries_pending.pop_front();
          void'(drain_before.pop_front());
          if ((primaries_pending.size() / 300) % 2 == 1) begin
            gap_cnt <= 0;
          end else begin
            pick_gap: begin
              int p;
              p = $urandom_range(99);
              gap_cnt <= (p < 70) ? 0 : (p < 95) ? $urandom_range(1, 3)
                                                 : $urandom_range(10, 40);
            end
          end
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // result stall generation, with one long hold-off
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      stall_cnt   <= 0;
      hold_cnt    <= 0;
      hold_done   <= 1'b0;
    end else if (hold_cnt > 0) begin
      out_stall_i <= 1'b1;
      hold_cnt    <= hold_cnt - 1;
    end else if (!hold_done && results_seen >= 500) begin
      out_stall_i <= 1'b1;
      hold_cnt    <= HOLD_CYCLES;
      hold_done   <= 1'b1;
    end else if (stall_cnt > 0) begin
      out_stall_i <= 1'b1;
      stall_cnt   <= stall_cnt - 1;
    end else if ((results_seen / 250) % 2 == 1) begin
      out_stall_i <= 1'b0;
    end else begin
      pick_stall: begin
        int p;
        p = $urandom_range(99);
        out_stall_i <= p < 25;
        stall_cnt   <= (p < 20) ? $urandom_range(0, 2) :
                       (p < 25) ? $urandom_range(10, 40) : 0;
      end
    end
  end

  // result checker
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (matrix_expected.size() == 0) begin
        $display("%0t: unexpected result %h", $time, out_req_o);
        errors++;
      end else begin
        check_fields: begin
          pcm_out_t want;
          logic [MAT_W-1:0] w_el [10];
          logic [MAT_W-1:0] g_el [10];
          want = matrix_expected.pop_front();
          w_el = '{want.m_r0c0, want.m_r0c1, want.m_r0c2, want.m_r1c0, want.m_r1c1,
                   want.m_r1c2, want.m_r2c0, want.m_r2c1, want.m_r2c2, want.status};
          g_el = '{out_req_o.m_r0c0, out_req_o.m_r0c1, out_req_o.m_r0c2,
                   out_req_o.m_r1c0, out_req_o.m_r1c1, out_req_o.m_r1c2,
                   out_req_o.m_r2c0, out_req_o.m_r2c1, out_req_o.m_r2c2,
                   out_req_o.status};
          for (int f = 0; f < 10; f++) begin
            if (g_el[f] !== w_el[f]) begin
              $display("%0t: %s expected %h got %h", $time, field_name[f], w_el[f],
                       g_el[f]);
              errors++;
            end
          end
          status_seen[want.status]++;
        end
      end
      results_seen++;
    end
  end

  // end of run
  initial begin
    errors = 0;
    results_seen = 0;
    wait (stim_ready);
    @(posedge clk_i);
    while (primaries_pending.size() > 0 || in_valid_i || matrix_expected.size() > 0)
      @(posedge clk_i);
    repeat (60) @(posedge clk_i);
    $display("checked %0d matrices: %0d ok, %0d zero y, %0d singular, %0d saturated",
             results_seen, status_seen[0], status_seen[1], status_seen[2],
             status_seen[3]);
    $display("with random gaps, a long output hold-off and a full drain mid-run");
    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // watchdog
  initial begin
    #5ms;
    $display("timeout with %0d results outstanding", matrix_expected.size());
    $display("Some tests failed");
    $finish;
  end

endmodule

// ===== files.f =====
rtl/core/pcm_pkg.sv
rtl/core/pcm_front.sv
rtl/core/pcm_queue.sv
rtl/core/pcm_div.sv
rtl/core/pcm_back.sv
rtl/core/primaries_conversion_matrix_unit.sv
sim/tb.sv
